@@ design/bmr_pkg.sv @@
// Package with shared constants and controller/datapath interface types for the broadcast ring.
package bmr_pkg;

    localparam int NODES_DEFAULT      = 32;
    localparam int DEPTH_DEFAULT      = 64;
    localparam int FRAME_BITS_DEFAULT = 64;

    localparam int NODE_W             = 5;
    localparam int FRAME_W            = 64;
    localparam int NCOUNT_W           = 6;
    localparam int RESET_NODE_COUNT   = 32;

    localparam int IN_TDATA_W         = 72;
    localparam int OUT_TDATA_W        = 64;

    typedef struct packed {
        logic send;
        logic recv;
        logic load_rd;
    } cmd_t;

    typedef struct packed {
        logic hit;
    } status_t;

endpackage

@@ design/bmr_ctrl.sv @@
// Controller state machine for the broadcast ring: handshakes and sequencing of ring reads.
module bmr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_op,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  bmr_pkg::status_t status,
    output bmr_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;
    logic   load_result;

    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == ST_IDLE) && out_free;
    assign accept      = in_valid && in_ready;
    assign cmd.send    = accept && !in_op;
    assign cmd.recv    = accept && in_op;
    assign cmd.load_rd = (state_reg == ST_READ);
    assign out_valid   = out_valid_reg;

    assign load_result = cmd.send || (cmd.recv && !status.hit) || cmd.load_rd;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.recv && status.hit)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/bmr_datapath.sv @@
// Datapath for the broadcast ring: node count, fill counts, write pointer, frame ring, result.
module bmr_datapath #(
    parameter int NODES      = bmr_pkg::NODES_DEFAULT,
    parameter int DEPTH      = bmr_pkg::DEPTH_DEFAULT,
    parameter int FRAME_BITS = bmr_pkg::FRAME_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bmr_pkg::NCOUNT_W-1:0] cfg_data,
    input  logic [bmr_pkg::NODE_W-1:0]   node,
    input  logic [bmr_pkg::FRAME_W-1:0]  frame_in,
    input  bmr_pkg::cmd_t                cmd,
    output bmr_pkg::status_t             status,
    output logic                         ok,
    output logic [bmr_pkg::FRAME_W-1:0]  frame_out
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int NIDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int RST_CNT = (bmr_pkg::RESET_NODE_COUNT < NODES) ?
                             bmr_pkg::RESET_NODE_COUNT : NODES;

    logic [bmr_pkg::NCOUNT_W-1:0] ncount_reg;
    logic [PTR_W-1:0]             wp_reg;
    logic [PTR_W-1:0]             wp_next;
    logic [CNT_W-1:0]             fill_reg [NODES];
    logic [FRAME_BITS-1:0]        ring_mem [DEPTH];
    logic [FRAME_BITS-1:0]        rd_data_reg;
    logic                         ok_reg;
    logic [bmr_pkg::FRAME_W-1:0]  frame_reg;

    logic [NIDX_W-1:0]            sel_idx;
    logic                         in_range;
    logic                         active;
    logic [CNT_W-1:0]             sel_fill;
    logic [CNT_W:0]               rp_sum;
    logic [CNT_W:0]               rp_wrap;
    logic [PTR_W-1:0]             rp;
    logic                         recv_hit;

    assign sel_idx    = NIDX_W'(node);
    assign in_range   = 32'(node) < NODES;
    assign active     = node < ncount_reg;
    assign sel_fill   = in_range ? fill_reg[sel_idx] : '0;
    assign status.hit = in_range && active && (sel_fill != '0);
    assign recv_hit   = cmd.recv && status.hit;

    assign rp_sum  = (CNT_W + 1)'(wp_reg) + (CNT_W + 1)'(DEPTH) - (CNT_W + 1)'(sel_fill);
    assign rp_wrap = (rp_sum >= (CNT_W + 1)'(DEPTH)) ? rp_sum - (CNT_W + 1)'(DEPTH) : rp_sum;
    assign rp      = rp_wrap[PTR_W-1:0];

    assign wp_next = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncount_reg <= bmr_pkg::NCOUNT_W'(RST_CNT);
            wp_reg     <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            ncount_reg <= (32'(cfg_data) > NODES) ? bmr_pkg::NCOUNT_W'(NODES) : cfg_data;
            wp_reg     <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (cmd.send)
        begin
            wp_reg <= wp_next;
            for (int i = 0; i < NODES; i++)
            begin
                if ((i < 32'(ncount_reg)) && (fill_reg[i] != CNT_W'(DEPTH)))
                begin
                    fill_reg[i] <= fill_reg[i] + 1'b1;
                end
            end
        end
        else if (recv_hit)
        begin
            fill_reg[sel_idx] <= sel_fill - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.send)
        begin
            ring_mem[wp_reg] <= frame_in[FRAME_BITS-1:0];
        end
        if (recv_hit)
        begin
            rd_data_reg <= ring_mem[rp];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.send)
        begin
            ok_reg    <= 1'b1;
            frame_reg <= '0;
        end
        else if (cmd.recv && !status.hit)
        begin
            ok_reg    <= 1'b0;
            frame_reg <= '0;
        end
        else if (cmd.load_rd)
        begin
            ok_reg    <= 1'b1;
            frame_reg <= bmr_pkg::FRAME_W'(rd_data_reg);
        end
    end

    assign ok        = ok_reg;
    assign frame_out = frame_reg;

endmodule

@@ design/broadcast_multi_reader_ring.sv @@
// Top level of the broadcast ring: one overwrite-oldest queue per node over one shared frame ring.
// A send or an empty receive gives its result in the cycle after the transaction; a delivered
// frame goes first to the registered read port of the frame ring, then to the result register.
// Sends are taken every cycle while the output is free; a delivering receive stalls the input.
// Reset (rst_n low, asynchronous) empties every queue, zeroes the write pointer and sets the
// node count to 32 or NODES if smaller; a node count write empties every queue the same way.
module broadcast_multi_reader_ring #(
    parameter int NODES      = bmr_pkg::NODES_DEFAULT,
    parameter int DEPTH      = bmr_pkg::DEPTH_DEFAULT,
    parameter int FRAME_BITS = bmr_pkg::FRAME_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bmr_pkg::NCOUNT_W-1:0]    cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bmr_pkg::IN_TDATA_W-1:0]  s_tdata,   // node, frame_in, zero fill
    input  logic                            s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bmr_pkg::OUT_TDATA_W-1:0] m_tdata,   // frame_out
    output logic                            m_tuser    // ok
);

    bmr_pkg::cmd_t    cmd;
    bmr_pkg::status_t status;

    bmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    bmr_datapath #(
        .NODES      (NODES),
        .DEPTH      (DEPTH),
        .FRAME_BITS (FRAME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .node      (s_tdata[bmr_pkg::NODE_W-1:0]),
        .frame_in  (s_tdata[bmr_pkg::NODE_W+bmr_pkg::FRAME_W-1:bmr_pkg::NODE_W]),
        .cmd       (cmd),
        .status    (status),
        .ok        (m_tuser),
        .frame_out (m_tdata)
    );

endmodule

@@ dv/bmr_tb_pkg.sv @@
// Operation codes and result type shared by the broadcast ring testbench files.
`timescale 1ns / 100ps

package bmr_tb_pkg;

    typedef enum logic {
        OP_SEND = 1'b0,
        OP_RECV = 1'b1
    } op_t;

    typedef struct packed {
        logic                        ok;
        logic [bmr_pkg::FRAME_W-1:0] frame;
    } frame_result_t;

endpackage

@@ dv/bmr_checker.sv @@
// Checker that predicts the broadcast ring queues and compares every output transaction.
`timescale 1ns / 100ps

module bmr_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bmr_pkg::NCOUNT_W-1:0]    cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bmr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bmr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    output int                              failures,
    output int                              pending,
    output int                              sends,
    output int                              delivered,
    output int                              empties
);

    localparam int RING_DEPTH = bmr_pkg::DEPTH_DEFAULT;
    localparam int NODE_SLOTS = bmr_pkg::NODES_DEFAULT;

    logic [bmr_pkg::FRAME_W-1:0]  frame_ring [RING_DEPTH];
    logic [5:0]                   wr_ptr;
    logic [5:0]                   rd_ptr [NODE_SLOTS];
    logic [6:0]                   fill [NODE_SLOTS];
    int unsigned                  active_nodes;
    bmr_tb_pkg::frame_result_t    awaited_q [$];
    int                           result_idx;

    function automatic int unsigned saturate_nodes(input logic [bmr_pkg::NCOUNT_W-1:0] v);
        return (v > NODE_SLOTS) ? NODE_SLOTS : v;
    endfunction

    function automatic void empty_all_queues();
        wr_ptr = '0;
        for (int i = 0; i < NODE_SLOTS; i++)
        begin
            rd_ptr[i] = '0;
            fill[i]   = '0;
        end
    endfunction

    // Applies one input transaction to the queue state and returns its result.
    function automatic bmr_tb_pkg::frame_result_t broadcast_or_fetch(
        input bmr_tb_pkg::op_t               op,
        input logic [bmr_pkg::NODE_W-1:0]    node,
        input logic [bmr_pkg::FRAME_W-1:0]   frame);
        bmr_tb_pkg::frame_result_t res;
        res = '0;
        if (op == bmr_tb_pkg::OP_SEND)
        begin
            for (int i = 0; i < NODE_SLOTS; i++)
            begin
                if (i < active_nodes)
                begin
                    if (fill[i] == RING_DEPTH)
                        rd_ptr[i] = 6'((rd_ptr[i] + 1) % RING_DEPTH);
                    else
                        fill[i] = fill[i] + 7'd1;
                end
            end
            frame_ring[wr_ptr] = frame;
            wr_ptr = 6'((wr_ptr + 1) % RING_DEPTH);
            res.ok = 1'b1;
        end
        else if (node < active_nodes && fill[node] > 0)
        begin
            res.ok    = 1'b1;
            res.frame = frame_ring[rd_ptr[node]];
            rd_ptr[node] = 6'((rd_ptr[node] + 1) % RING_DEPTH);
            fill[node]   = fill[node] - 7'd1;
        end
        return res;
    endfunction

    function automatic void note_failure();
        failures++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bmr_tb_pkg::frame_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
                frame_ring[i] = '0;
            empty_all_queues();
            active_nodes = saturate_nodes(bmr_pkg::NCOUNT_W'(bmr_pkg::RESET_NODE_COUNT));
            awaited_q.delete();
            result_idx = 0;
            failures   = 0;
            sends      = 0;
            delivered  = 0;
            empties    = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_nodes = saturate_nodes(cfg_data);
                empty_all_queues();
            end
            if (m_tvalid && m_tready)
            begin
                if (awaited_q.size() == 0)
                begin
                    note_failure();
                    if (failures <= 10)
                        $display("%0t: output transaction %0d with none expected: %s %0b %s %h",
                                 $realtime, result_idx, "ok", m_tuser, "frame", m_tdata);
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (want.ok !== m_tuser || want.frame !== m_tdata)
                    begin
                        note_failure();
                        if (failures <= 10)
                        begin
                            $display("%0t: output transaction %0d: expected ok %0b frame %h,",
                                     $realtime, result_idx, want.ok, want.frame);
                            $display("    got ok %0b frame %h", m_tuser, m_tdata);
                        end
                    end
                end
                result_idx++;
            end
            if (s_tvalid && s_tready)
            begin
                want = broadcast_or_fetch(bmr_tb_pkg::op_t'(s_tuser),
                                          s_tdata[bmr_pkg::NODE_W-1:0],
                                          s_tdata[bmr_pkg::NODE_W +: bmr_pkg::FRAME_W]);
                if (bmr_tb_pkg::op_t'(s_tuser) == bmr_tb_pkg::OP_SEND)
                    sends++;
                else if (want.ok)
                    delivered++;
                else
                    empties++;
                awaited_q.push_back(want);
            end
            pending <= awaited_q.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top that drives the broadcast ring and reports the checker's verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int ITEM_TARGET = 1650;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [bmr_pkg::NCOUNT_W-1:0]    cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bmr_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bmr_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;

    int failures;
    int pending;
    int sends;
    int delivered;
    int empties;

    int items_issued = 0;
    int cfg_writes = 0;
    int cur_nodes = bmr_pkg::RESET_NODE_COUNT;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    broadcast_multi_reader_ring i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bmr_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .failures  (failures),
        .pending   (pending),
        .sends     (sends),
        .delivered (delivered),
        .empties   (empties)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("broadcast_multi_reader_ring: mismatch");
        $finish;
    end

    // Mostly short idle spells, with an occasional long one.
    function automatic int idle_len(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                hold = idle_len(rx_idle_on);
                m_tready <= (hold == 0);
                if (hold > 0)
                    hold--;
            end
        end
    end

    task automatic issue(input bmr_tb_pkg::op_t op,
                         input logic [bmr_pkg::NODE_W-1:0] node,
                         input logic [bmr_pkg::FRAME_W-1:0] frame);
        int gap;
        gap = idle_len(tx_idle_on);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(bmr_pkg::IN_TDATA_W - bmr_pkg::NODE_W - bmr_pkg::FRAME_W){1'b0}},
                     frame, node};
        do @(posedge clk); while (!s_tready);
        items_issued++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_node_count(input logic [bmr_pkg::NCOUNT_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_nodes = (v > bmr_pkg::NODES_DEFAULT) ? bmr_pkg::NODES_DEFAULT : v;
        cfg_writes++;
    endtask

    function automatic logic [bmr_pkg::FRAME_W-1:0] any_frame();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [bmr_pkg::NODE_W-1:0] any_node();
        if (cur_nodes > 0 && $urandom_range(0, 99) < 85)
            return bmr_pkg::NODE_W'($urandom_range(0, cur_nodes - 1));
        return bmr_pkg::NODE_W'($urandom_range(0, bmr_pkg::NODES_DEFAULT - 1));
    endfunction

    function automatic logic [bmr_pkg::NODE_W-1:0] rand_node();
        return bmr_pkg::NODE_W'($urandom);
    endfunction

    function automatic logic [bmr_pkg::FRAME_W-1:0] rand_word();
        return bmr_pkg::FRAME_W'($urandom);
    endfunction

    initial
    begin
        int kind;
        int len;
        int send_pct;
        int flood_node;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queues, extreme frames, count of zero, saturation, inactive node.
        issue(bmr_tb_pkg::OP_RECV, 5'd0, '0);
        issue(bmr_tb_pkg::OP_RECV, 5'd31, '0);
        issue(bmr_tb_pkg::OP_SEND, 5'd31, '0);
        issue(bmr_tb_pkg::OP_SEND, 5'd0, '1);
        issue(bmr_tb_pkg::OP_SEND, 5'd17, 64'hA5A5_5A5A_F00F_0FF0);
        issue(bmr_tb_pkg::OP_RECV, 5'd0, '1);
        issue(bmr_tb_pkg::OP_RECV, 5'd31, '0);
        issue(bmr_tb_pkg::OP_RECV, 5'd0, '0);
        issue(bmr_tb_pkg::OP_RECV, 5'd0, '0);
        issue(bmr_tb_pkg::OP_RECV, 5'd0, '0);
        set_node_count(6'd0);
        issue(bmr_tb_pkg::OP_SEND, 5'd0, 64'h0123_4567_89AB_CDEF);
        issue(bmr_tb_pkg::OP_RECV, 5'd0, '0);
        set_node_count(6'd63);
        issue(bmr_tb_pkg::OP_SEND, 5'd0, 64'hFEDC_BA98_7654_3210);
        issue(bmr_tb_pkg::OP_RECV, 5'd31, '0);
        issue(bmr_tb_pkg::OP_RECV, 5'd31, '0);
        set_node_count(6'd1);
        issue(bmr_tb_pkg::OP_SEND, 5'd3, 64'h8000_0000_0000_0001);
        issue(bmr_tb_pkg::OP_RECV, 5'd1, '0);
        issue(bmr_tb_pkg::OP_RECV, 5'd0, '0);
        set_node_count(6'd33);
        issue(bmr_tb_pkg::OP_SEND, 5'd0, '1);
        issue(bmr_tb_pkg::OP_RECV, 5'd31, '0);

        while (items_issued < ITEM_TARGET)
        begin
            case ($urandom_range(0, 7))
                0:       set_node_count(bmr_pkg::NCOUNT_W'($urandom_range(0, 63)));
                1:       set_node_count(6'd32);
                2:       set_node_count(6'd63);
                3:       set_node_count(6'd1);
                4:       set_node_count(bmr_pkg::NCOUNT_W'($urandom_range(2, 8)));
                default: set_node_count(bmr_pkg::NCOUNT_W'($urandom_range(1, 32)));
            endcase
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 3);
            if (kind == 3)
            begin
                // Overfill the queues, then drain one node past empty.
                len = bmr_pkg::DEPTH_DEFAULT + $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    issue(bmr_tb_pkg::OP_SEND, rand_node(), any_frame());
                flood_node = (cur_nodes > 0) ? $urandom_range(0, cur_nodes - 1) : 0;
                for (int i = 0; i < bmr_pkg::DEPTH_DEFAULT + 2; i++)
                    issue(bmr_tb_pkg::OP_RECV, bmr_pkg::NODE_W'(flood_node), rand_word());
                for (int i = 0; i < 4; i++)
                    issue(bmr_tb_pkg::OP_RECV, any_node(), rand_word());
            end
            else
            begin
                send_pct = (kind == 0) ? 50 : (kind == 1) ? 75 : 25;
                len = $urandom_range(80, 160);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 99) < send_pct)
                        issue(bmr_tb_pkg::OP_SEND, rand_node(), any_frame());
                    else
                        issue(bmr_tb_pkg::OP_RECV, any_node(), any_frame());
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d transactions: %0d sends, %0d frames delivered,",
                 items_issued, sends, delivered);
        $display("%0d empty receives, with %0d node count writes between phases.",
                 empties, cfg_writes);
        if (failures == 0 && pending == 0)
            $display("broadcast_multi_reader_ring: match");
        else
            $display("broadcast_multi_reader_ring: mismatch");
        $finish;
    end

endmodule
